FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfc check failed");

// Next-cycle implication, disabled while reset is low.
`define PFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfc check failed");

`endif

FILE: src/pfc_pkg.sv
// Shared types, codes and square geometry helpers for the Playfair block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int SIDE        = 5;
  localparam int CELLS       = SIDE * SIDE;
  localparam int NUM_LETTERS = 26;
  localparam int LW          = 5;
  localparam int KW          = 3;
  localparam int FW          = 2;
  localparam int RCW         = $clog2(SIDE);

  typedef logic [LW-1:0]  letter_t;
  typedef logic [RCW-1:0] rc_t;

  localparam letter_t LET_I     = 5'd8;
  localparam letter_t LET_J     = 5'd9;
  localparam letter_t LET_X     = 5'd23;
  localparam letter_t LET_SPACE = 5'd26;

  typedef enum logic [KW-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_KEY    = 3'd1,
    KIND_FINISH = 3'd2,
    KIND_MSG    = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef enum logic [FW-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_ODD   = 2'd1,
    FAULT_NOKEY = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    SEL_R0   = 2'd0,
    SEL_R1   = 2'd1,
    SEL_SPEC = 2'd2
  } osel_e;

  typedef struct packed {
    logic   clear_key;
    logic   place_key;
    logic   walk_start;
    logic   walk_step;
    logic   set_ready;
    logic   hold_load;
    logic   hold_clr;
    logic   pair_load;
    logic   pair_use_x;
    logic   pair_dec;
    logic   pos_rd;
    logic   pos_rd_b;
    logic   pa_cap;
    logic   sq_rd;
    logic   sq_rd_hi;
    logic   addr1_cap;
    logic   r0_cap;
    logic   spec_load;
    logic   spec_end;
    fault_e spec_fault;
    logic   out_load;
    osel_e  out_sel;
  } cmd_t;

  typedef struct packed {
    logic dir;
    logic sq_ready;
    logic holding;
    logic is_space;
    logic same_held;
    logic walk_last;
    logic out_free;
    logic r0_skip;
    logic r1_skip;
  } stat_t;

  function automatic rc_t row_of(input letter_t p);
    rc_t r;
    r = '0;
    for (int k = 1; k < SIDE; k++) begin
      if (p >= LW'(k * SIDE)) begin
        r = RCW'(k);
      end
    end
    return r;
  endfunction

  function automatic rc_t col_of(input letter_t p);
    letter_t t;
    t = p - LW'(row_of(p)) * LW'(SIDE);
    return t[RCW-1:0];
  endfunction

  function automatic rc_t step_rc(input rc_t v, input logic dec);
    rc_t r;
    if (dec) begin
      r = (v == '0) ? RCW'(SIDE - 1) : v - RCW'(1);
    end else begin
      r = (v == RCW'(SIDE - 1)) ? '0 : v + RCW'(1);
    end
    return r;
  endfunction

  function automatic letter_t cell_of(input rc_t r, input rc_t c);
    return LW'(r) * LW'(SIDE) + LW'(c);
  endfunction

endpackage

`default_nettype wire

FILE: src/pfc_ifs.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on pfc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if;
  logic                     valid;
  logic                     ready;
  logic [pfc_pkg::KW-1:0]   kind;
  logic [pfc_pkg::LW-1:0]   letter;

  modport source (output valid, output kind, output letter, input ready);
  modport sink   (input valid, input kind, input letter, output ready);
endinterface

interface pfc_out_if;
  logic                     valid;
  logic                     ready;
  logic [pfc_pkg::LW-1:0]   out_letter;
  logic                     end_marker;
  logic [pfc_pkg::FW-1:0]   fault;

  modport source (output valid, output out_letter, output end_marker, output fault,
                  input ready);
  modport sink   (input valid, input out_letter, input end_marker, input fault,
                  output ready);
endinterface

`default_nettype wire

FILE: src/pfc_ctrl.sv
// Sequencing state machine: decodes input words and steps the datapath.
// Depends on pfc_pkg (cmd_t, stat_t, codes).
`timescale 1ns / 1ps
`default_nettype none

module pfc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [pfc_pkg::KW-1:0] in_kind_i,
  output logic                   in_ready_o,
  input  pfc_pkg::stat_t         stat_i,
  output pfc_pkg::cmd_t          cmd_o
);
  import pfc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_WALK = 9'b000000010,
    ST_PA   = 9'b000000100,
    ST_PB   = 9'b000001000,
    ST_SQ0  = 9'b000010000,
    ST_SQ1  = 9'b000100000,
    ST_E0   = 9'b001000000,
    ST_E1   = 9'b010000000,
    ST_SPEC = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   end_after_q, end_after_d;

  always_comb begin
    state_d     = state_q;
    end_after_d = end_after_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_e'(in_kind_i))
            KIND_CLEAR: begin
              cmd_o.clear_key = 1'b1;
            end
            KIND_KEY: begin
              cmd_o.place_key = !stat_i.sq_ready;
            end
            KIND_FINISH: begin
              if (!stat_i.sq_ready) begin
                cmd_o.walk_start = 1'b1;
                state_d          = ST_WALK;
              end
            end
            KIND_MSG: begin
              if (stat_i.is_space) begin
                state_d = ST_IDLE;
              end else if (!stat_i.sq_ready) begin
                cmd_o.spec_load  = 1'b1;
                cmd_o.spec_end   = 1'b0;
                cmd_o.spec_fault = FAULT_NOKEY;
                state_d          = ST_SPEC;
              end else if (!stat_i.holding) begin
                cmd_o.hold_load = 1'b1;
              end else if (!stat_i.dir && stat_i.same_held) begin
                // doubled letter: pad with X, second letter stays held
                cmd_o.pair_load  = 1'b1;
                cmd_o.pair_use_x = 1'b1;
                end_after_d      = 1'b0;
                state_d          = ST_PA;
              end else begin
                cmd_o.pair_load = 1'b1;
                cmd_o.pair_dec  = stat_i.dir;
                cmd_o.hold_clr  = 1'b1;
                end_after_d     = 1'b0;
                state_d         = ST_PA;
              end
            end
            KIND_END: begin
              cmd_o.hold_clr  = 1'b1;
              cmd_o.spec_load = 1'b1;
              cmd_o.spec_end  = 1'b1;
              if (!stat_i.sq_ready) begin
                cmd_o.spec_fault = FAULT_NOKEY;
                state_d          = ST_SPEC;
              end else if (stat_i.holding && stat_i.dir) begin
                cmd_o.spec_fault = FAULT_ODD;
                state_d          = ST_SPEC;
              end else if (stat_i.holding) begin
                cmd_o.spec_fault = FAULT_NONE;
                cmd_o.pair_load  = 1'b1;
                cmd_o.pair_use_x = 1'b1;
                end_after_d      = 1'b1;
                state_d          = ST_PA;
              end else begin
                cmd_o.spec_fault = FAULT_NONE;
                state_d          = ST_SPEC;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          cmd_o.set_ready = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_PA: begin
        cmd_o.pos_rd = 1'b1;
        state_d      = ST_PB;
      end
      ST_PB: begin
        cmd_o.pos_rd   = 1'b1;
        cmd_o.pos_rd_b = 1'b1;
        cmd_o.pa_cap   = 1'b1;
        state_d        = ST_SQ0;
      end
      ST_SQ0: begin
        cmd_o.sq_rd     = 1'b1;
        cmd_o.addr1_cap = 1'b1;
        state_d         = ST_SQ1;
      end
      ST_SQ1: begin
        cmd_o.sq_rd    = 1'b1;
        cmd_o.sq_rd_hi = 1'b1;
        cmd_o.r0_cap   = 1'b1;
        state_d        = ST_E0;
      end
      ST_E0: begin
        if (stat_i.r0_skip) begin
          state_d = ST_E1;
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_R0;
          state_d        = ST_E1;
        end
      end
      ST_E1: begin
        if (stat_i.r1_skip || stat_i.out_free) begin
          cmd_o.out_load = !stat_i.r1_skip;
          cmd_o.out_sel  = SEL_R1;
          state_d        = end_after_q ? ST_SPEC : ST_IDLE;
        end
      end
      ST_SPEC: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_SPEC;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      end_after_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      end_after_q <= end_after_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/pfc_dp.sv
// Datapath: key square and letter position memories, pair geometry, output register.
// Depends on pfc_pkg (cmd_t, stat_t, geometry functions).
`timescale 1ns / 1ps
`default_nettype none

module pfc_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic [pfc_pkg::LW-1:0] in_letter_i,
  input  pfc_pkg::cmd_t          cmd_i,
  output pfc_pkg::stat_t         stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [pfc_pkg::LW-1:0] out_letter_o,
  output logic                   out_end_o,
  output logic [pfc_pkg::FW-1:0] out_fault_o
);
  import pfc_pkg::*;

  logic                   dir_q;
  logic [NUM_LETTERS-1:0] placed_q;
  letter_t                fill_q;
  letter_t                walk_q;
  logic                   holding_q;
  logic                   ready_q;
  logic                   out_valid_q;

  letter_t held_q, a_q, b_q, pa_q, addr1_q, r0_q;
  logic    dec_q;
  logic    spec_end_q;
  fault_e  spec_fault_q;
  letter_t pos_rdata_q, sq_rdata_q;
  letter_t out_letter_q;
  logic    out_end_q;
  fault_e  out_fault_q;

  letter_t pos_mem [NUM_LETTERS];
  letter_t sq_mem  [CELLS];

  letter_t place_let;
  logic    place_en;
  letter_t pos_sel, pos_raddr, sq_raddr;
  letter_t addr0, addr1;
  rc_t     ra, ca, rb, cb, ra_n, ca_n, rb_n, cb_n;

  // key placement: first appearance only, J never placed
  assign place_let = cmd_i.walk_step ? walk_q : in_letter_i;
  assign place_en  = (cmd_i.walk_step || cmd_i.place_key)
                   && (place_let < LW'(NUM_LETTERS)) && (place_let != LET_J)
                   && !placed_q[place_let] && (fill_q < LW'(CELLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q  <= '0;
      fill_q    <= '0;
      holding_q <= 1'b0;
      ready_q   <= 1'b0;
    end else if (cmd_i.clear_key) begin
      placed_q  <= '0;
      fill_q    <= '0;
      holding_q <= 1'b0;
      ready_q   <= 1'b0;
    end else begin
      if (place_en) begin
        placed_q[place_let] <= 1'b1;
        fill_q              <= fill_q + LW'(1);
      end
      if (cmd_i.set_ready) begin
        ready_q <= 1'b1;
      end
      if (cmd_i.hold_load) begin
        holding_q <= 1'b1;
      end else if (cmd_i.hold_clr) begin
        holding_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (cmd_i.walk_start) begin
      walk_q <= '0;
    end else if (cmd_i.walk_step) begin
      walk_q <= walk_q + LW'(1);
    end
  end

  // position table, J looked up as I
  assign pos_sel   = cmd_i.pos_rd_b ? b_q : a_q;
  assign pos_raddr = (pos_sel == LET_J) ? LET_I : pos_sel;

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      pos_mem[place_let] <= fill_q;
    end
    if (cmd_i.pos_rd) begin
      pos_rdata_q <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_q] <= place_let;
    end
    if (cmd_i.sq_rd) begin
      sq_rdata_q <= sq_mem[sq_raddr];
    end
  end

  // pair geometry: pa_q and the second position in pos_rdata_q
  always_comb begin
    ra   = row_of(pa_q);
    ca   = col_of(pa_q);
    rb   = row_of(pos_rdata_q);
    cb   = col_of(pos_rdata_q);
    ra_n = ra;
    ca_n = ca;
    rb_n = rb;
    cb_n = cb;
    if (ra == rb) begin
      ca_n = step_rc(ca, dec_q);
      cb_n = step_rc(cb, dec_q);
    end else if (ca == cb) begin
      ra_n = step_rc(ra, dec_q);
      rb_n = step_rc(rb, dec_q);
    end else begin
      ca_n = cb;
      cb_n = ca;
    end
  end

  assign addr0    = cell_of(ra_n, ca_n);
  assign addr1    = cell_of(rb_n, cb_n);
  assign sq_raddr = cmd_i.sq_rd_hi ? addr1_q : addr0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_load) begin
      held_q <= in_letter_i;
    end
    if (cmd_i.pair_load) begin
      a_q   <= held_q;
      b_q   <= cmd_i.pair_use_x ? LET_X : in_letter_i;
      dec_q <= cmd_i.pair_dec;
    end
    if (cmd_i.pa_cap) begin
      pa_q <= pos_rdata_q;
    end
    if (cmd_i.addr1_cap) begin
      addr1_q <= addr1;
    end
    if (cmd_i.r0_cap) begin
      r0_q <= sq_rdata_q;
    end
    if (cmd_i.spec_load) begin
      spec_end_q   <= cmd_i.spec_end;
      spec_fault_q <= cmd_i.spec_fault;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        SEL_R0: begin
          out_letter_q <= r0_q;
          out_end_q    <= 1'b0;
          out_fault_q  <= FAULT_NONE;
        end
        SEL_R1: begin
          out_letter_q <= sq_rdata_q;
          out_end_q    <= 1'b0;
          out_fault_q  <= FAULT_NONE;
        end
        SEL_SPEC: begin
          out_letter_q <= '0;
          out_end_q    <= spec_end_q;
          out_fault_q  <= spec_fault_q;
        end
        default: begin
          out_letter_q <= '0;
          out_end_q    <= 1'b0;
          out_fault_q  <= FAULT_NONE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_end_o    = out_end_q;
  assign out_fault_o  = out_fault_q;

  assign stat_o.dir       = dir_q;
  assign stat_o.sq_ready  = ready_q;
  assign stat_o.holding   = holding_q;
  assign stat_o.is_space  = (in_letter_i >= LET_SPACE);
  assign stat_o.same_held = (held_q == in_letter_i);
  assign stat_o.walk_last = (walk_q == LW'(NUM_LETTERS - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.r0_skip   = dec_q && (r0_q == LET_X);
  assign stat_o.r1_skip   = dec_q && (sq_rdata_q == LET_X);

endmodule

`default_nettype wire

FILE: src/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: controller plus datapath.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_ctrl, pfc_dp.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+-------------------------------
//   in_i     | in  | valid/ready      | kind[2:0], letter[4:0]
//   out_o    | out | valid/ready      | out_letter[4:0], end_marker, fault[1:0]
//   cfg      | in  | cfg_we_i only    | cfg_wdata_i = direction
//
// Clear, key letter, space and a first message letter are handled within ST_IDLE.
// Finish key starts the fill walk in ST_WALK, one letter of the alphabet per cycle.
// A completed pair runs ST_PA, ST_PB, ST_SQ0, ST_SQ1, ST_E0 and ST_E1, with two
// reads each on the position and square memories; END adds ST_SPEC for the marker.
// Output stalls hold the sequencer; one result word waits in the output register.
// Reset clears control state; the square contents are rebuilt by each key.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  pfc_in_if.sink     in_i,
  pfc_out_if.source  out_o
);
  import pfc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_letter_i  (in_i.letter),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_letter_o (out_o.out_letter),
    .out_end_o    (out_o.end_marker),
    .out_fault_o  (out_o.fault)
  );

endmodule

`default_nettype wire

FILE: src/pfc_checker.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on assert_macros.svh and pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfc_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [pfc_pkg::LW-1:0] out_letter,
  input logic                   end_marker,
  input logic [pfc_pkg::FW-1:0] fault
);
  import pfc_pkg::*;

  `PFC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_letter) && $stable(end_marker) && $stable(fault))
  `PFC_ASSERT_IMP(a_marker_no_letter, clk_i, rst_ni, out_valid && (end_marker || fault == FAULT_NOKEY), out_letter == '0)
  `PFC_ASSERT_IMP(a_odd_on_end, clk_i, rst_ni, out_valid && fault == FAULT_ODD, end_marker)
  `PFC_ASSERT_IMP(a_letter_range, clk_i, rst_ni, out_valid && !end_marker, out_letter < LW'(NUM_LETTERS))

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_letter (out_o.out_letter),
  .end_marker (out_o.end_marker),
  .fault      (out_o.fault)
);

`default_nettype wire
